// ----- sv/range_add_range_sum_blocks_macros.svh -----
// ----------------------------------------------------------------------------
// range_add_range_sum_blocks assertion macros
// Shared concurrent assertion forms for the range add / range sum block.
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_RANGE_SUM_BLOCKS_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_BLOCKS_MACROS_SVH

// same-cycle implication
`define RASB_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RASB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rasb_pkg.sv -----
// ----------------------------------------------------------------------------
// rasb_pkg
// Types and fixed constants of the range add / range sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package rasb_pkg;

	localparam int VAL_W = 64;
	localparam int IDX_W = 10;
	localparam int OPD_W = 32;
	localparam int OPC_W = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUM  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef enum logic [2:0] {
		STEP_ELEM,
		STEP_BLOCK,
		STEP_FLUSH,
		STEP_LOAD,
		STEP_CLEAR
	} step_kind_t;

	// one memory step issued by the sequencer
	typedef struct packed {
		logic       vld;
		step_kind_t kind;
		logic       is_sum;
		logic       clr_blk;
	} step_t;

	// block store entry: pending add and true block sum
	typedef struct packed {
		logic [VAL_W-1:0] pend;
		logic [VAL_W-1:0] bsum;
	} blk_entry_t;

endpackage

`default_nettype wire

// ----- sv/rasb_div.sv -----
// ----------------------------------------------------------------------------
// rasb_div
// Block locator: index divided by the block length through a constant
// reciprocal multiply; the quotient is registered on start, the remainder is then registered from it.
// ----------------------------------------------------------------------------
`default_nettype none

module rasb_div #(
	parameter int XW        = 12,
	parameter int BLOCK_LEN = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [XW-1:0]                dividend,
	output logic                              done,
	output logic [XW-1:0]                     quotient,
	output logic [$clog2(BLOCK_LEN)-1:0]      remainder
);

	localparam int OW  = $clog2(BLOCK_LEN);
	localparam int SH  = XW + OW;
	localparam int MW  = XW + 2;
	localparam int PRW = 2 * XW + OW + 2;
	// ceil(2^SH / BLOCK_LEN); the truncated product is exact for any XW-bit index
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));
	localparam logic [XW-1:0] DIVISOR = XW'(BLOCK_LEN);

	logic          run_q;
	logic          done_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] quo_q;
	logic [OW-1:0] rem_q;

	logic [PRW-1:0] prod;
	logic [XW-1:0]  quo_n;
	logic [XW-1:0]  diff;

	always_comb begin
		prod  = PRW'(dividend) * PRW'(RECIP);
		quo_n = prod[SH +: XW];
		diff  = x_q - XW'(quo_q * DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= dividend;
			quo_q <= quo_n;
		end
		if (run_q) begin
			rem_q <= diff[OW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- sv/rasb_dp.sv -----
// ----------------------------------------------------------------------------
// rasb_dp
// Element and block memories with read-modify-write pipeline and sum
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_add_range_sum_blocks_macros.svh"

module rasb_dp #(
	parameter int ARRAY_SIZE = 1024,
	parameter int BLOCK_LEN  = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rasb_pkg::step_t                     step,
	input  wire logic [$clog2(ARRAY_SIZE)-1:0]       elem_addr,
	input  wire logic [((((ARRAY_SIZE + BLOCK_LEN - 1) / BLOCK_LEN) > 1) ?
		$clog2((ARRAY_SIZE + BLOCK_LEN - 1) / BLOCK_LEN) : 1)-1:0] blk_addr,
	input  wire logic [rasb_pkg::VAL_W-1:0]          operand,
	input  wire logic [rasb_pkg::VAL_W-1:0]          operand_blk,
	input  wire logic                                acc_clr,
	output logic [rasb_pkg::VAL_W-1:0]               acc,
	output logic                                     idle
);

	localparam int AW = $clog2(ARRAY_SIZE);
	localparam int BC = (ARRAY_SIZE + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int BW = (BC > 1) ? $clog2(BC) : 1;
	localparam int VW = rasb_pkg::VAL_W;

	logic [VW-1:0]        emem [ARRAY_SIZE];
	rasb_pkg::blk_entry_t bmem [BC];

	// stage 1: read data back
	logic                 vld_s1;
	rasb_pkg::step_kind_t kind_s1;
	logic                 sum_s1;
	logic [AW-1:0]        ea_s1;
	logic [BW-1:0]        ba_s1;
	logic [VW-1:0]        e_rd_s1;
	rasb_pkg::blk_entry_t b_rd_s1;

	// stage 2: sum term and tail of a load
	logic                 term_vld_s2;
	logic [VW-1:0]        term_s2;
	logic                 load_s2;
	logic [BW-1:0]        ba_s2;
	logic [VW-1:0]        pend_s2;
	logic [VW-1:0]        x_s2;
	logic [VW-1:0]        z_s2;

	logic [VW-1:0]        delta_q;
	logic [VW-1:0]        acc_q;

	logic                 e_we;
	logic [AW-1:0]        e_wa;
	logic [VW-1:0]        e_wd;
	logic                 b_we;
	logic [BW-1:0]        b_wa;
	rasb_pkg::blk_entry_t b_wd;
	logic                 is_clear;

	assign is_clear = step.vld && (step.kind == rasb_pkg::STEP_CLEAR);

	always_comb begin
		e_we      = 1'b0;
		e_wa      = elem_addr;
		e_wd      = '0;
		b_we      = 1'b0;
		b_wa      = blk_addr;
		b_wd.pend = '0;
		b_wd.bsum = '0;
		if (is_clear) begin
			e_we = 1'b1;
			b_we = step.clr_blk;
		end else begin
			if (vld_s1) begin
				case (kind_s1)
					rasb_pkg::STEP_ELEM: begin
						if (!sum_s1) begin
							e_we = 1'b1;
							e_wa = ea_s1;
							e_wd = e_rd_s1 + operand;
						end
					end
					rasb_pkg::STEP_LOAD: begin
						// stored value excludes the block's pending add
						e_we = 1'b1;
						e_wa = ea_s1;
						e_wd = operand - b_rd_s1.pend;
					end
					rasb_pkg::STEP_BLOCK: begin
						if (!sum_s1) begin
							b_we      = 1'b1;
							b_wa      = ba_s1;
							b_wd.pend = b_rd_s1.pend + operand;
							b_wd.bsum = b_rd_s1.bsum + operand_blk;
						end
					end
					rasb_pkg::STEP_FLUSH: begin
						b_we      = 1'b1;
						b_wa      = ba_s1;
						b_wd.pend = b_rd_s1.pend;
						b_wd.bsum = b_rd_s1.bsum + delta_q;
					end
					default: begin
					end
				endcase
			end
			if (load_s2) begin
				b_we      = 1'b1;
				b_wa      = ba_s2;
				b_wd.pend = pend_s2;
				b_wd.bsum = x_s2 + z_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			emem[e_wa] <= e_wd;
		end
		if (b_we) begin
			bmem[b_wa] <= b_wd;
		end
		e_rd_s1 <= emem[elem_addr];
		b_rd_s1 <= bmem[blk_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			term_vld_s2 <= 1'b0;
			load_s2     <= 1'b0;
		end else begin
			vld_s1      <= step.vld && !is_clear;
			term_vld_s2 <= vld_s1 && sum_s1 &&
				(kind_s1 == rasb_pkg::STEP_ELEM || kind_s1 == rasb_pkg::STEP_BLOCK);
			load_s2     <= vld_s1 && (kind_s1 == rasb_pkg::STEP_LOAD);
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= step.kind;
		sum_s1  <= step.is_sum;
		ea_s1   <= elem_addr;
		ba_s1   <= blk_addr;
		term_s2 <= (kind_s1 == rasb_pkg::STEP_ELEM) ? e_rd_s1 + b_rd_s1.pend : b_rd_s1.bsum;
		ba_s2   <= ba_s1;
		pend_s2 <= b_rd_s1.pend;
		x_s2    <= operand - e_rd_s1;
		z_s2    <= b_rd_s1.bsum - b_rd_s1.pend;
		if (acc_clr) begin
			delta_q <= '0;
		end else if (vld_s1 && kind_s1 == rasb_pkg::STEP_ELEM && !sum_s1) begin
			delta_q <= delta_q + operand;
		end else if (vld_s1 && kind_s1 == rasb_pkg::STEP_FLUSH) begin
			delta_q <= '0;
		end
		if (acc_clr) begin
			acc_q <= '0;
		end else if (term_vld_s2) begin
			acc_q <= acc_q + term_s2;
		end
	end

	assign acc  = acc_q;
	assign idle = !vld_s1 && !term_vld_s2 && !load_s2;

	`RASB_ASSERT_NOW(a_blk_port_single, clk, arst_n, load_s2, !(vld_s1 && (kind_s1 == rasb_pkg::STEP_BLOCK || kind_s1 == rasb_pkg::STEP_FLUSH)), "block store written twice in one cycle")
	`RASB_ASSERT_NOW(a_clear_alone, clk, arst_n, is_clear, !vld_s1 && !load_s2 && !term_vld_s2, "clear overlaps a transaction")
	`RASB_ASSERT_NOW(a_clr_when_idle, clk, arst_n, acc_clr, idle, "accumulator cleared with steps in flight")

endmodule

`default_nettype wire

// ----- sv/range_add_range_sum_blocks.sv -----
// ----------------------------------------------------------------------------
// range_add_range_sum_blocks
// Blocked array with range add and range sum; sequencer over the memories.
// ----------------------------------------------------------------------------
//  channel  | handshake                | fields
//  ---------+--------------------------+--------------------------------------
//  command  | start, busy              | opcode, left_index, right_index,
//           |                          | operand_value
//  result   | done (one-cycle strobe)  | range_sum
//
//  After reset a clearing pass over every element address zeroes both stores;
//  busy stays high meanwhile. Each accepted command first passes through the
//  block locator. A load issues a single load step. An add issues one memory
//  step per element of a partial block, per full block and a flush per partial
//  block; a sum issues one step per element and per full block, done in the
//  first cycle with busy low. Empty or ignored commands leave busy low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_add_range_sum_blocks_macros.svh"

module range_add_range_sum_blocks #(
	parameter int ARRAY_SIZE = 1024,
	parameter int BLOCK_LEN  = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [rasb_pkg::OPC_W-1:0]         opcode,
	input  wire logic [rasb_pkg::IDX_W-1:0]         left_index,
	input  wire logic [rasb_pkg::IDX_W-1:0]         right_index,
	input  wire logic signed [rasb_pkg::OPD_W-1:0]  operand_value,
	output logic                                    done,
	output logic signed [rasb_pkg::VAL_W-1:0]       range_sum
);

	localparam int AW  = $clog2(ARRAY_SIZE);
	localparam int BC  = (ARRAY_SIZE + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int BW  = (BC > 1) ? $clog2(BC) : 1;
	localparam int OW  = $clog2(BLOCK_LEN);
	localparam int XW0 = (AW > rasb_pkg::IDX_W) ? AW : rasb_pkg::IDX_W;
	localparam int XW  = XW0 + 2;
	localparam int LW  = $clog2(BLOCK_LEN + 1);
	localparam int PW  = rasb_pkg::OPD_W + LW + 1;
	localparam int VW  = rasb_pkg::VAL_W;
	localparam logic [LW:0] BL_C = (LW + 1)'(BLOCK_LEN);

	rasb_pkg::state_t  state_q, state_d;
	rasb_pkg::opcode_t op_q, op_in;

	logic [AW-1:0] clr_q;
	logic [XW-1:0] cur_q;
	logic [XW-1:0] r_q;
	logic [BW-1:0] blk_q;
	logic [OW-1:0] off_q;
	logic          flush_q;
	logic [BW-1:0] flush_blk_q;
	logic [VW-1:0] k_q;
	logic [VW-1:0] kbl_q;
	logic          done_q;
	logic [VW-1:0] range_sum_q;

	logic [XW-1:0] l_x, r_x, r_cl;
	logic          empty, load_ok, full_blk, last_in_blk;
	logic [VW-1:0] k64, kbl64;
	logic signed [PW-1:0] kbl_full;

	rasb_pkg::step_t step;
	logic [AW-1:0]   elem_addr;
	logic [BW-1:0]   blk_addr;
	logic            div_start, acc_clr, do_elem, do_blk, do_flush, fin;
	logic            div_done;
	logic [XW-1:0]   div_quo;
	logic [OW-1:0]   div_rem;
	logic [VW-1:0]   acc;
	logic            dp_idle;

	always_comb begin
		op_in    = rasb_pkg::opcode_t'(opcode);
		l_x      = XW'(left_index);
		r_x      = XW'(right_index);
		r_cl     = (r_x >= XW'(ARRAY_SIZE)) ? XW'(ARRAY_SIZE - 1) : r_x;
		load_ok  = l_x < XW'(ARRAY_SIZE);
		empty    = !load_ok || (l_x > r_cl);
		k64      = VW'(operand_value);
		kbl_full = PW'(operand_value) * PW'($signed(BL_C));
		kbl64    = VW'(kbl_full);
		// a block counts as covered only from its first element to its last
		full_blk    = (off_q == '0) && (cur_q + XW'(BLOCK_LEN - 1) <= r_q);
		last_in_blk = (off_q == OW'(BLOCK_LEN - 1)) || (cur_q == r_q);
	end

	always_comb begin
		state_d   = state_q;
		step      = '{vld: 1'b0, kind: rasb_pkg::STEP_ELEM, is_sum: 1'b0, clr_blk: 1'b0};
		step.is_sum = (op_q == rasb_pkg::OP_SUM);
		elem_addr = cur_q[AW-1:0];
		blk_addr  = blk_q;
		div_start = 1'b0;
		acc_clr   = 1'b0;
		do_elem   = 1'b0;
		do_blk    = 1'b0;
		do_flush  = 1'b0;
		fin       = 1'b0;
		unique case (state_q)
			rasb_pkg::ST_CLEAR: begin
				step.vld     = 1'b1;
				step.kind    = rasb_pkg::STEP_CLEAR;
				step.clr_blk = XW'(clr_q) < XW'(BC);
				elem_addr    = clr_q;
				blk_addr     = clr_q[BW-1:0];
				if (clr_q == AW'(ARRAY_SIZE - 1)) begin
					state_d = rasb_pkg::ST_IDLE;
				end
			end
			rasb_pkg::ST_IDLE: begin
				if (start) begin
					acc_clr = 1'b1;
					unique case (op_in) inside
						rasb_pkg::OP_LOAD: begin
							if (load_ok) begin
								div_start = 1'b1;
								state_d   = rasb_pkg::ST_DIV;
							end
						end
						rasb_pkg::OP_ADD, rasb_pkg::OP_SUM: begin
							if (!empty) begin
								div_start = 1'b1;
								state_d   = rasb_pkg::ST_DIV;
							end
						end
						default: begin
						end
					endcase
				end
			end
			rasb_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = (op_q == rasb_pkg::OP_LOAD) ? rasb_pkg::ST_LOAD
						: rasb_pkg::ST_WALK;
				end
			end
			rasb_pkg::ST_LOAD: begin
				step.vld  = 1'b1;
				step.kind = rasb_pkg::STEP_LOAD;
				state_d   = rasb_pkg::ST_DRAIN;
			end
			rasb_pkg::ST_WALK: begin
				if (flush_q) begin
					// fold the partial block's accumulated add into its sum
					step.vld  = 1'b1;
					step.kind = rasb_pkg::STEP_FLUSH;
					blk_addr  = flush_blk_q;
					do_flush  = 1'b1;
				end else if (cur_q > r_q) begin
					state_d = rasb_pkg::ST_DRAIN;
				end else if (full_blk) begin
					step.vld  = 1'b1;
					step.kind = rasb_pkg::STEP_BLOCK;
					do_blk    = 1'b1;
				end else begin
					step.vld  = 1'b1;
					step.kind = rasb_pkg::STEP_ELEM;
					do_elem   = 1'b1;
				end
			end
			rasb_pkg::ST_DRAIN: begin
				if (dp_idle) begin
					fin     = 1'b1;
					state_d = rasb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rasb_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rasb_pkg::ST_CLEAR;
			op_q    <= rasb_pkg::OP_NONE;
			clr_q   <= '0;
			flush_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == rasb_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (start && state_q == rasb_pkg::ST_IDLE) begin
				op_q    <= op_in;
				flush_q <= 1'b0;
				if (op_in == rasb_pkg::OP_SUM && empty) begin
					done_q <= 1'b1;
				end
			end
			if (do_flush) begin
				flush_q <= 1'b0;
			end else if (do_elem && op_q == rasb_pkg::OP_ADD && last_in_blk) begin
				flush_q <= 1'b1;
			end
			if (fin && op_q == rasb_pkg::OP_SUM) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == rasb_pkg::ST_IDLE) begin
			cur_q       <= l_x;
			r_q         <= r_cl;
			k_q         <= k64;
			kbl_q       <= kbl64;
			range_sum_q <= '0;
		end
		if (state_q == rasb_pkg::ST_DIV && div_done) begin
			blk_q <= div_quo[BW-1:0];
			off_q <= div_rem;
		end
		if (do_blk) begin
			cur_q <= cur_q + XW'(BLOCK_LEN);
			blk_q <= blk_q + BW'(1);
		end
		if (do_elem) begin
			cur_q       <= cur_q + XW'(1);
			flush_blk_q <= blk_q;
			if (off_q == OW'(BLOCK_LEN - 1)) begin
				off_q <= '0;
				blk_q <= blk_q + BW'(1);
			end else begin
				off_q <= off_q + OW'(1);
			end
		end
		if (fin) begin
			range_sum_q <= acc;
		end
	end

	rasb_div #(
		.XW        (XW),
		.BLOCK_LEN (BLOCK_LEN)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (l_x),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	rasb_dp #(
		.ARRAY_SIZE (ARRAY_SIZE),
		.BLOCK_LEN  (BLOCK_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.elem_addr   (elem_addr),
		.blk_addr    (blk_addr),
		.operand     (k_q),
		.operand_blk (kbl_q),
		.acc_clr     (acc_clr),
		.acc         (acc),
		.idle        (dp_idle)
	);

	assign busy      = (state_q != rasb_pkg::ST_IDLE);
	assign done      = done_q;
	assign range_sum = range_sum_q;

	`RASB_ASSERT_NOW(a_done_sum_only, clk, arst_n, done, op_q == rasb_pkg::OP_SUM, "result strobe outside a sum transaction")
	`RASB_ASSERT_NOW(a_idle_drained, clk, arst_n, state_q == rasb_pkg::ST_IDLE, dp_idle, "idle with memory steps in flight")
	`RASB_ASSERT_NOW(a_flush_add_only, clk, arst_n, step.vld && step.kind == rasb_pkg::STEP_FLUSH, op_q == rasb_pkg::OP_ADD, "block flush outside a range add")
	`RASB_ASSERT_NOW(a_div_in_wait, clk, arst_n, div_done, state_q == rasb_pkg::ST_DIV, "locator finished while not awaited")

endmodule

`default_nettype wire

// ----- sim/range_sum_checker.sv -----
// ----------------------------------------------------------------------------
// range_sum_checker
// Watches the command and result channels of range_add_range_sum_blocks,
// keeps a blocked shadow of the array and compares every returned range sum.
// ----------------------------------------------------------------------------
`default_nettype none

module range_sum_checker #(
	parameter int ARRAY_SIZE = 1024,
	parameter int BLOCK_LEN  = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               busy,
	input  wire logic [rasb_pkg::OPC_W-1:0]         opcode,
	input  wire logic [rasb_pkg::IDX_W-1:0]         left_index,
	input  wire logic [rasb_pkg::IDX_W-1:0]         right_index,
	input  wire logic signed [rasb_pkg::OPD_W-1:0]  operand_value,
	input  wire logic                               done,
	input  wire logic signed [rasb_pkg::VAL_W-1:0]  range_sum,
	output int                                      fail_count,
	output int                                      sums_outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLK_CNT = (ARRAY_SIZE + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int VW      = rasb_pkg::VAL_W;
	localparam int OW      = rasb_pkg::OPD_W;

	// shadow state: elements exclude their block's pending add
	logic [VW-1:0] elem_val [ARRAY_SIZE];
	logic [VW-1:0] blk_sum  [BLK_CNT];
	logic [VW-1:0] blk_pend [BLK_CNT];
	logic [VW-1:0] expected_sums [$];
	logic [VW-1:0] want_sum;
	int            mismatches;

	function automatic void fold_pending(input int unsigned b);
		if (b >= BLK_CNT || blk_pend[b] == '0)
			return;
		for (int unsigned i = b * BLOCK_LEN; i < (b + 1) * BLOCK_LEN && i < ARRAY_SIZE; i++)
			elem_val[i] += blk_pend[b];
		blk_pend[b] = '0;
	endfunction

	function automatic void add_elems(input int unsigned b, input int unsigned lo,
			input int unsigned hi, input logic [VW-1:0] k);
		for (int unsigned i = lo; i <= hi; i++) begin
			elem_val[i] += k;
			blk_sum[b]  += k;
		end
	endfunction

	function automatic logic [VW-1:0] sum_elems(input int unsigned lo, input int unsigned hi);
		logic [VW-1:0] s;
		s = '0;
		for (int unsigned i = lo; i <= hi; i++)
			s += elem_val[i];
		return s;
	endfunction

	function automatic void add_to_range(input int unsigned l, input int unsigned r,
			input logic [VW-1:0] k);
		int unsigned bl;
		int unsigned br;
		bl = l / BLOCK_LEN;
		br = r / BLOCK_LEN;
		fold_pending(bl);
		if (bl == br) begin
			add_elems(bl, l, r, k);
			return;
		end
		fold_pending(br);
		add_elems(bl, l, (bl + 1) * BLOCK_LEN - 1, k);
		// fully covered blocks only move their pending add and block sum
		for (int unsigned b = bl + 1; b < br; b++) begin
			blk_pend[b] += k;
			blk_sum[b]  += k * 64'(BLOCK_LEN);
		end
		add_elems(br, br * BLOCK_LEN, r, k);
	endfunction

	function automatic logic [VW-1:0] sum_of_range(input int unsigned l, input int unsigned r);
		int unsigned   bl;
		int unsigned   br;
		logic [VW-1:0] s;
		bl = l / BLOCK_LEN;
		br = r / BLOCK_LEN;
		fold_pending(bl);
		if (bl == br)
			return sum_elems(l, r);
		fold_pending(br);
		s = sum_elems(l, (bl + 1) * BLOCK_LEN - 1);
		for (int unsigned b = bl + 1; b < br; b++)
			s += blk_sum[b];
		s += sum_elems(br * BLOCK_LEN, r);
		return s;
	endfunction

	function automatic void apply_command(input rasb_pkg::opcode_t op, input int unsigned l,
			input int unsigned r, input logic [OW-1:0] v);
		logic [VW-1:0] k;
		int unsigned   b;
		bit            empty;
		k = {{(VW - OW){v[OW-1]}}, v};
		if (r >= ARRAY_SIZE)
			r = ARRAY_SIZE - 1;
		empty = (l >= ARRAY_SIZE) || (l > r);
		case (op)
			rasb_pkg::OP_LOAD: begin
				if (l < ARRAY_SIZE) begin
					b = l / BLOCK_LEN;
					fold_pending(b);
					blk_sum[b] += k - elem_val[l];
					elem_val[l] = k;
				end
			end
			rasb_pkg::OP_ADD: begin
				if (!empty)
					add_to_range(l, r, k);
			end
			rasb_pkg::OP_SUM: begin
				expected_sums.push_back(empty ? '0 : sum_of_range(l, r));
			end
			default: ;
		endcase
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ARRAY_SIZE; i++)
				elem_val[i] = '0;
			for (int i = 0; i < BLK_CNT; i++) begin
				blk_sum[i]  = '0;
				blk_pend[i] = '0;
			end
			expected_sums.delete();
			mismatches = 0;
			fail_count       <= 0;
			sums_outstanding <= 0;
		end else begin
			// results first: a strobe always belongs to an earlier transaction
			if (done) begin
				if (expected_sums.size() == 0) begin
					note_failure($sformatf("range_sum %0d with no sum outstanding",
						range_sum));
				end else begin
					want_sum = expected_sums.pop_front();
					if (want_sum !== range_sum)
						note_failure($sformatf("range_sum mismatch: expected %0d (%h) got %0d (%h)",
							$signed(want_sum), want_sum, range_sum, range_sum));
				end
			end
			if (start && !busy)
				apply_command(rasb_pkg::opcode_t'(opcode), left_index, right_index,
					operand_value);
			fail_count       <= mismatches;
			sums_outstanding <= expected_sums.size();
		end
	end

endmodule

`default_nettype wire

// ----- sim/range_add_range_sum_blocks_test.sv -----
// ----------------------------------------------------------------------------
// range_add_range_sum_blocks_test
// Drives directed then random load / add / sum transactions under varying
// sender idling; range_sum_checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_range_sum_blocks_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ARRAY_SIZE     = 1024;
	localparam int BLOCK_LEN      = 32;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int IW             = rasb_pkg::IDX_W;
	localparam int OW             = rasb_pkg::OPD_W;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [rasb_pkg::OPC_W-1:0]        opcode;
	logic [IW-1:0]                     left_index;
	logic [IW-1:0]                     right_index;
	logic signed [OW-1:0]              operand_value;
	logic                              done;
	logic signed [rasb_pkg::VAL_W-1:0] range_sum;

	int fail_count;
	int sums_outstanding;
	int idle_pct;
	int stall_cycles;

	range_add_range_sum_blocks #(
		.ARRAY_SIZE(ARRAY_SIZE),
		.BLOCK_LEN (BLOCK_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.left_index   (left_index),
		.right_index  (right_index),
		.operand_value(operand_value),
		.done         (done),
		.range_sum    (range_sum)
	);

	range_sum_checker #(
		.ARRAY_SIZE(ARRAY_SIZE),
		.BLOCK_LEN (BLOCK_LEN)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.left_index      (left_index),
		.right_index     (right_index),
		.operand_value   (operand_value),
		.done            (done),
		.range_sum       (range_sum),
		.fail_count      (fail_count),
		.sums_outstanding(sums_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// counts cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	task automatic send_command(input rasb_pkg::opcode_t op, input logic [IW-1:0] l,
			input logic [IW-1:0] r, input logic [OW-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		opcode        <= op;
		left_index    <= l;
		right_index   <= r;
		operand_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_for_sums;
		start <= 1'b0;
		@(posedge clk);
		while (sums_outstanding != 0)
			@(posedge clk);
	endtask

	task automatic random_commands(input int count);
		int                sent;
		rasb_pkg::opcode_t op;
		int unsigned       sel;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       tmp;
		logic [OW-1:0]     v;
		sent = 0;
		while (sent < count) begin
			sel = $urandom_range(99);
			if (sel < 25)
				op = rasb_pkg::OP_LOAD;
			else if (sel < 55)
				op = rasb_pkg::OP_ADD;
			else if (sel < 95)
				op = rasb_pkg::OP_SUM;
			else
				op = rasb_pkg::OP_NONE;
			lo  = $urandom_range(1023);
			hi  = $urandom_range(1023);
			case ($urandom_range(9))
				0, 1: begin
					if (lo > hi) begin
						tmp = lo;
						lo  = hi;
						hi  = tmp;
					end
				end
				2, 3, 4: hi = lo + $urandom_range(40);
				5, 6: begin
					// block aligned: whole blocks at both ends
					lo = $urandom_range(31) * BLOCK_LEN;
					hi = lo + $urandom_range(3) * BLOCK_LEN + BLOCK_LEN - 1;
				end
				7, 8: hi = lo + $urandom_range(200);
				default: ; // raw order, often an empty range
			endcase
			if (hi > 1023)
				hi = 1023;
			case ($urandom_range(9))
				0:       v = 32'h7FFF_FFFF;
				1:       v = 32'h8000_0000;
				2:       v = 32'($urandom_range(20)) - 32'd10;
				default: v = $urandom;
			endcase
			send_command(op, lo[IW-1:0], hi[IW-1:0], v);
			if (op != rasb_pkg::OP_NONE)
				sent++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		opcode        = rasb_pkg::OP_LOAD;
		left_index    = '0;
		right_index   = '0;
		operand_value = '0;
		idle_pct      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, partial and full blocks, empty ranges
		idle_pct = 30;
		send_command(rasb_pkg::OP_SUM, 10'd0, 10'd1023, 32'h0);
		send_command(rasb_pkg::OP_LOAD, 10'd0, 10'd0, 32'h7FFF_FFFF);
		send_command(rasb_pkg::OP_LOAD, 10'd1023, 10'd0, 32'h8000_0000);
		send_command(rasb_pkg::OP_LOAD, 10'd5, 10'd1023, 32'hFFFF_FFFF);
		send_command(rasb_pkg::OP_SUM, 10'd0, 10'd1023, 32'h0);
		send_command(rasb_pkg::OP_ADD, 10'd0, 10'd1023, 32'h7FFF_FFFF);
		send_command(rasb_pkg::OP_ADD, 10'd33, 10'd130, -32'sd5);
		send_command(rasb_pkg::OP_ADD, 10'd64, 10'd95, 32'd3);
		send_command(rasb_pkg::OP_ADD, 10'd40, 10'd40, 32'h8000_0000);
		send_command(rasb_pkg::OP_LOAD, 10'd70, 10'd0, 32'd123);  // block with pending add
		send_command(rasb_pkg::OP_SUM, 10'd31, 10'd32, 32'h0);
		send_command(rasb_pkg::OP_SUM, 10'd60, 10'd135, 32'h0);
		send_command(rasb_pkg::OP_SUM, 10'd64, 10'd127, 32'h0);
		send_command(rasb_pkg::OP_SUM, 10'd32, 10'd1000, 32'hFFFF_FFFF);
		send_command(rasb_pkg::OP_SUM, 10'd10, 10'd9, 32'h0);
		send_command(rasb_pkg::OP_SUM, 10'd1023, 10'd0, 32'h0);
		send_command(rasb_pkg::OP_ADD, 10'd500, 10'd499, 32'd99);
		send_command(rasb_pkg::OP_NONE, 10'd3, 10'd700, 32'd55);
		send_command(rasb_pkg::OP_SUM, 10'd1023, 10'd1023, 32'h0);
		send_command(rasb_pkg::OP_ADD, 10'd1023, 10'd1023, 32'd1);
		send_command(rasb_pkg::OP_SUM, 10'd992, 10'd1023, 32'h0);
		send_command(rasb_pkg::OP_SUM, 10'd0, 10'd1023, 32'h0);

		random_commands(430);
		wait_for_sums();

		idle_pct = 85;
		random_commands(430);

		idle_pct = 0;
		random_commands(440);

		wait_for_sums();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && sums_outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/rasb_pkg.sv
sv/rasb_div.sv
sv/rasb_dp.sv
sv/range_add_range_sum_blocks.sv
sim/range_sum_checker.sv
sim/range_add_range_sum_blocks_test.sv
